// ===== hdl/mws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, register indexes, reset values and the serial control type
// of the modular weighted sum block. No dependencies.
package mws_pkg;

   localparam int WORD_W = 64;
   // A modulus of zero stands for 2^64, so the modulus carries one more bit.
   localparam int MOD_W = WORD_W + 1;
   localparam int CNT_W = $clog2(WORD_W);
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT = 1'd1;

   localparam logic [MOD_W-1:0] MODULUS_RESET = {1'b0, {WORD_W{1'b1}}};
   localparam logic [WORD_W-1:0] WEIGHT_RESET = {{(WORD_W-1){1'b0}}, 1'b1};
   localparam logic [WORD_W-1:0] POWER_RESET = {{(WORD_W-1){1'b0}}, 1'b1};
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

   // Load starts a serial unit on fresh operands, step advances it one bit.
   typedef struct packed {
      logic load;
      logic step;
   } serial_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/mws_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the modular weighted sum block: input words,
// result words and register writes. Depends on mws_pkg.
interface mws_req_if;
   logic                       valid;
   logic                       ready;
   logic [mws_pkg::WORD_W-1:0] value;
   logic                       last_value;
   modport source (output valid, output value, output last_value, input ready);
   modport sink (input valid, input value, input last_value, output ready);
endinterface

interface mws_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mws_pkg::WORD_W-1:0] residue;
   modport source (output valid, output residue, input ready);
   modport sink (input valid, input residue, output ready);
endinterface

interface mws_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mws_pkg::CSR_INDEX_W-1:0] index;
   logic [mws_pkg::WORD_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mws_serial_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial reduction of a 64-bit operand by a variable modulus, one bit a step.
// Depends on mws_pkg.
module mws_serial_reduce (
   input  wire logic                           clock,
   input  wire mws_pkg::serial_ctrl_type       ctrl,
   input  wire logic [mws_pkg::MOD_W-1:0]      q_ext,
   input  wire logic [mws_pkg::WORD_W-1:0]     operand,
   output logic      [mws_pkg::WORD_W-1:0]     result
);

   logic [mws_pkg::WORD_W-1:0] shift_ff, shift_in;
   logic [mws_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [mws_pkg::MOD_W-1:0]  trial;

   always_comb begin
      trial = {rem_ff, shift_ff[mws_pkg::WORD_W-1]};
      shift_in = shift_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         shift_in = operand;
         rem_in = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[mws_pkg::WORD_W-2:0], 1'b0};
         // The remainder stays below q, so one subtraction is enough.
         if (trial >= q_ext) begin
            rem_in = mws_pkg::WORD_W'(trial - q_ext);
         end else begin
            rem_in = trial[mws_pkg::WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff <= rem_in;
   end

   assign result = rem_ff;

endmodule
`default_nettype wire

// ===== hdl/mws_serial_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial modular multiplier, double and add with the multiplier scanned
// from its top bit. The parallel operand must already be below q. Depends on mws_pkg.
module mws_serial_mulmod (
   input  wire logic                           clock,
   input  wire mws_pkg::serial_ctrl_type       ctrl,
   input  wire logic [mws_pkg::MOD_W-1:0]      q_ext,
   input  wire logic [mws_pkg::WORD_W-1:0]     mult_a,
   input  wire logic [mws_pkg::WORD_W-1:0]     mult_b,
   output logic      [mws_pkg::WORD_W-1:0]     result
);

   logic [mws_pkg::WORD_W-1:0] shift_ff, shift_in;
   logic [mws_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [mws_pkg::MOD_W:0]    sum;
   logic [mws_pkg::MOD_W:0]    q_once;
   logic [mws_pkg::MOD_W:0]    q_twice;

   always_comb begin
      q_once = {1'b0, q_ext};
      q_twice = {q_ext, 1'b0};
      // 2*acc + a stays below 3q: subtract q or 2q, chosen by parallel compares.
      sum = {1'b0, acc_ff, 1'b0}
            + (shift_ff[mws_pkg::WORD_W-1] ? {2'b00, mult_a} : '0);
      shift_in = shift_ff;
      acc_in = acc_ff;
      if (ctrl.load) begin
         shift_in = mult_b;
         acc_in = '0;
      end else if (ctrl.step) begin
         shift_in = {shift_ff[mws_pkg::WORD_W-2:0], 1'b0};
         if (sum >= q_twice) begin
            acc_in = mws_pkg::WORD_W'(sum - q_twice);
         end else if (sum >= q_once) begin
            acc_in = mws_pkg::WORD_W'(sum - q_once);
         end else begin
            acc_in = sum[mws_pkg::WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      acc_ff <= acc_in;
   end

   assign result = acc_ff;

endmodule
`default_nettype wire

// ===== hdl/modular_weighted_sum_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the modular weighted sum block: sequencer, state, registers and
// result register. Depends on mws_pkg, mws_if, mws_serial_reduce, mws_serial_mulmod.
//
//   channel   direction  carries                      handshake
//   req_port  in         value[63:0], last_value      valid/ready
//   rsp_port  out        residue[63:0]                valid/ready
//   csr_port  in         index (0 modulus, 1 weight), valid/ready, always ready
//                        data[63:0]
//
// When the stored power is below the modulus, an accepted word passes through a load
// state, the bit-serial multipliers and a final modular add, then returns to idle,
// where the next word is accepted. When the stored power is not below the modulus
// (after the modulus is lowered mid-run, or with a modulus of one), that word first
// reduces the power: a load state, the serial reducer steps and a state that stores
// the result. Reset is synchronous: modulus returns to all ones, weight to one, the
// running sum to zero and the running power to one. A last word whose result finds
// the result register still full waits in its final cycle until the register drains.
module modular_weighted_sum_top (
   input  wire logic   clock,
   input  wire logic   reset,
   mws_req_if.sink     req_port,
   mws_rsp_if.source   rsp_port,
   mws_csr_if.sink     csr_port
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PREP,
      ST_POWER,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type state_ff, state_in;

   // Architectural registers and running state.
   logic [mws_pkg::MOD_W-1:0]  q_ext_ff, q_ext_in;
   logic [mws_pkg::WORD_W-1:0] weight_ff, weight_in;
   logic [mws_pkg::WORD_W-1:0] sum_ff, sum_in;
   logic [mws_pkg::WORD_W-1:0] power_ff, power_in;

   // The word in flight and the bit counter of the serial units.
   logic [mws_pkg::WORD_W-1:0] value_ff, value_in;
   logic                       last_ff, last_in;
   logic [mws_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [mws_pkg::WORD_W-1:0] residue_ff, residue_in;

   mws_pkg::serial_ctrl_type   red_ctrl;
   mws_pkg::serial_ctrl_type   mul_ctrl;
   logic [mws_pkg::WORD_W-1:0] red_operand;
   logic [mws_pkg::WORD_W-1:0] red_result;
   logic [mws_pkg::WORD_W-1:0] term_result;
   logic [mws_pkg::WORD_W-1:0] next_power;
   logic                       power_big;
   logic [mws_pkg::MOD_W-1:0]  add_sum;
   logic [mws_pkg::WORD_W-1:0] add_red;
   logic                       req_fire;
   logic                       rsp_free;

   // One reducer serves two purposes: in the prepare phase it brings a stale
   // power below the modulus, and alongside the multiplies it reduces the sum.
   mws_serial_reduce u_reduce (
      .clock   (clock),
      .ctrl    (red_ctrl),
      .q_ext   (q_ext_ff),
      .operand (red_operand),
      .result  (red_result)
   );

   // Term of this word: value times the current power. Only the power has to
   // be below q; the serially scanned value may be any 64-bit pattern.
   mws_serial_mulmod u_term_mul (
      .clock  (clock),
      .ctrl   (mul_ctrl),
      .q_ext  (q_ext_ff),
      .mult_a (power_ff),
      .mult_b (value_ff),
      .result (term_result)
   );

   // Next power: current power times the weight, in parallel with the term.
   mws_serial_mulmod u_power_mul (
      .clock  (clock),
      .ctrl   (mul_ctrl),
      .q_ext  (q_ext_ff),
      .mult_a (power_ff),
      .mult_b (weight_ff),
      .result (next_power)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.residue = residue_ff;

   assign req_fire = req_port.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;
   assign power_big = ({1'b0, power_ff} >= q_ext_ff);
   assign red_operand = power_big ? power_ff : sum_ff;

   // Both addends are below q, so the sum needs at most one subtraction.
   always_comb begin
      add_sum = {1'b0, red_result} + {1'b0, term_result};
      if (add_sum >= q_ext_ff) begin
         add_red = mws_pkg::WORD_W'(add_sum - q_ext_ff);
      end else begin
         add_red = add_sum[mws_pkg::WORD_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      q_ext_in = q_ext_ff;
      weight_in = weight_ff;
      sum_in = sum_ff;
      power_in = power_ff;
      value_in = value_ff;
      last_in = last_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      residue_in = residue_ff;
      red_ctrl = '0;
      mul_ctrl = '0;

      // Writes must arrive only while no word is in flight; the block does not enforce it.
      if (csr_port.valid) begin
         unique case (csr_port.index)
            mws_pkg::CSR_MODULUS: q_ext_in = {csr_port.data == '0, csr_port.data};
            mws_pkg::CSR_WEIGHT:  weight_in = csr_port.data;
            default:              q_ext_in = q_ext_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               value_in = req_port.value;
               last_in = req_port.last_value;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            red_ctrl.load = 1'b1;
            cnt_in = mws_pkg::CNT_LAST;
            if (power_big) begin
               state_in = ST_PREP;
            end else begin
               mul_ctrl.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_PREP: begin
            red_ctrl.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_POWER;
            end
         end
         ST_POWER: begin
            // All 64 reducer steps are done, so the reduced power is stored.
            power_in = red_result;
            state_in = ST_LOAD;
         end
         ST_MUL: begin
            red_ctrl.step = 1'b1;
            mul_ctrl.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!last_ff) begin
               sum_in = add_red;
               power_in = next_power;
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               residue_in = add_red;
               sum_in = '0;
               power_in = mws_pkg::POWER_RESET;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      last_ff <= last_in;
      cnt_ff <= cnt_in;
      residue_ff <= residue_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ext_ff <= mws_pkg::MODULUS_RESET;
         weight_ff <= mws_pkg::WEIGHT_RESET;
         sum_ff <= '0;
         power_ff <= mws_pkg::POWER_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ext_ff <= q_ext_in;
         weight_ff <= weight_in;
         sum_ff <= sum_in;
         power_ff <= power_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the modular weighted sum block and the bind that attaches
// them to the top level. Depends on mws_pkg and modular_weighted_sum_top.
module mws_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mws_pkg::WORD_W-1:0]      rsp_residue,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready,
   input wire logic [mws_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [mws_pkg::WORD_W-1:0]      csr_data
);

   // Shadow of the modulus as written through the register port.
   logic [mws_pkg::WORD_W-1:0] modulus_ff, modulus_in;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_valid && csr_ready && csr_index == mws_pkg::CSR_MODULUS) begin
         modulus_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '1;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_residue))
      else $error("stalled result word changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again while a word is in flight");

   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (modulus_ff == '0 || rsp_residue < modulus_ff))
      else $error("residue not below the modulus");

endmodule

bind modular_weighted_sum_top mws_checker u_mws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_residue (rsp_port.residue),
   .csr_valid   (csr_port.valid),
   .csr_ready   (csr_port.ready),
   .csr_index   (csr_port.index),
   .csr_data    (csr_port.data)
);
`default_nettype wire

// ===== verif/tb_modular_weighted_sum_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of modular_weighted_sum_top: checks every residue against
// a predictor of the modular weighted sum under random handshake idling.
// Depends on mws_pkg, mws_if and the RTL of the block.
module tb_modular_weighted_sum_top;

   localparam int WORD_W = mws_pkg::WORD_W;
   localparam int CSR_INDEX_W = mws_pkg::CSR_INDEX_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS = mws_pkg::CSR_MODULUS;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT = mws_pkg::CSR_WEIGHT;
   localparam logic [mws_pkg::MOD_W-1:0] MODULUS_RESET = mws_pkg::MODULUS_RESET;
   localparam logic [WORD_W-1:0] WEIGHT_RESET = mws_pkg::WEIGHT_RESET;
   localparam logic [WORD_W-1:0] POWER_RESET = mws_pkg::POWER_RESET;

   // Longest random idle of either side, in cycles.
   localparam int unsigned MAX_GAP = 12;
   // Long enough for a word to finish, including the power reduction that a modulus
   // change may need first. Wait this long before touching the registers, and again
   // at the end of the run.
   localparam int unsigned SETTLE_CYCLES = 160;
   // Watchdog limit of the whole test, above the slowest legal run.
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned RANDOM_WORDS = 650;
   localparam int unsigned PHASES = 8;
   localparam int unsigned PRESSURE_HOLD = 1500;
   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mws_req_if req_bus ();
   mws_rsp_if rsp_bus ();
   mws_csr_if csr_bus ();

   modular_weighted_sum_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: a copy of both registers and of the running sum and power.
   // A modulus of zero means no reduction at all, that is arithmetic mod 2^64.
   logic [WORD_W-1:0] cfg_modulus = MODULUS_RESET[WORD_W-1:0];
   logic [WORD_W-1:0] cfg_weight = WEIGHT_RESET;
   logic [WORD_W-1:0] run_sum = '0;
   logic [WORD_W-1:0] run_power = POWER_RESET;
   logic [WORD_W-1:0] expected_residues[$];

   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   // When set, the matching side does not idle at all.
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   // A long stall of the result side, picked up and counted down by the sink.
   int unsigned hold_request = 0;

   function automatic int unsigned draw_gap(input bit steady);
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Full 64x64 product reduced mod q; both operands are reduced first, since
   // after a modulus change the stored power may lie above the new q.
   function automatic logic [WORD_W-1:0] mod_mul(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] q);
      logic [2*WORD_W-1:0] prod;
      if (q == '0) begin
         return a * b;
      end
      prod = {{WORD_W{1'b0}}, a % q} * {{WORD_W{1'b0}}, b % q};
      prod = prod % {{WORD_W{1'b0}}, q};
      return prod[WORD_W-1:0];
   endfunction

   // Exact sum mod q, with one extra bit so that it cannot overflow.
   function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] q);
      logic [WORD_W:0] s;
      if (q == '0) begin
         return a + b;
      end
      s = {1'b0, a % q} + {1'b0, b % q};
      if (s >= {1'b0, q}) begin
         s = s - {1'b0, q};
      end
      return s[WORD_W-1:0];
   endfunction

   // Folds one accepted word into the running sum and advances the power. A last
   // word closes the run: its residue becomes an expectation and the state restarts.
   function automatic void predict_word(input logic [WORD_W-1:0] value,
                                        input logic is_last);
      logic [WORD_W-1:0] term;
      term = mod_mul(value, run_power, cfg_modulus);
      run_sum = mod_add(run_sum, term, cfg_modulus);
      run_power = mod_mul(run_power, cfg_weight, cfg_modulus);
      if (is_last) begin
         expected_residues.push_back(run_sum);
         run_sum = '0;
         run_power = POWER_RESET;
      end
   endfunction

   // Values are uniform half the time, so that every bit takes both levels; the rest are
   // edge values near zero and near the top of the range, or uniform values shifted down.
   function automatic logic [WORD_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: return WORD_W'($urandom_range(0, 15));
         1: return ALL_ONES - WORD_W'($urandom_range(0, 15));
         2: return {$urandom, $urandom} >> $urandom_range(1, WORD_W - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_modulus();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return WORD_W'(1);
         2, 3: return WORD_W'($urandom_range(2, 300));
         4: return ALL_ONES;
         5, 6: return ({$urandom, $urandom} >> $urandom_range(1, WORD_W - 2)) | WORD_W'(2);
         default: return {$urandom, $urandom} | {1'b1, {(WORD_W-1){1'b0}}};
      endcase
   endfunction

   task automatic check_residue(input logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (expected_residues.size() == 0) begin
         $display("%0t: residue with none expected: expected none, actual %h", $time, got);
         errors++;
      end else begin
         want = expected_residues.pop_front();
         if (got !== want) begin
            $display("%0t: residue mismatch: expected %h, actual %h", $time, want, got);
            errors++;
         end
      end
   endtask

   // Offers one word after a random gap and returns at the edge that accepts it.
   // Valid is left high, so that a following word with no gap goes out back to back.
   task automatic send_word(input logic [WORD_W-1:0] value, input logic is_last);
      int unsigned gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.last_value <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_word(value, is_last);
   endtask

   // Takes the input side idle, waits for every open residue, then lets the block
   // finish any word that has no result of its own.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (expected_residues.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Valid stays high on return; the caller lowers it after its last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [WORD_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (index == CSR_MODULUS) begin
         cfg_modulus = data;
      end else begin
         cfg_weight = data;
      end
   endtask

   task automatic configure(input logic [WORD_W-1:0] modulus,
                            input logic [WORD_W-1:0] weight);
      settle_idle();
      write_register(CSR_MODULUS, modulus);
      write_register(CSR_WEIGHT, weight);
      csr_bus.valid <= 1'b0;
   endtask

   // Under the reset settings q is 2^64-1 and every weight is one, so each
   // residue is the plain sum of the run mod 2^64-1.
   task automatic test_reset_settings();
      send_word('0, 1'b1);
      send_word(ALL_ONES, 1'b1);
      send_word(ALL_ONES - 1, 1'b1);
      send_word(ALL_ONES - 1, 1'b0);
      send_word(WORD_W'(3), 1'b1);
   endtask

   task automatic test_modulus_extremes();
      // Modulus zero: products and sums simply wrap at 64 bits.
      configure('0, ALL_ONES);
      send_word(ALL_ONES, 1'b0);
      send_word(ALL_ONES, 1'b0);
      send_word({1'b1, {(WORD_W-1){1'b0}}}, 1'b1);
      // Modulus one: every residue collapses to zero.
      configure(WORD_W'(1), {$urandom, $urandom});
      send_word(ALL_ONES, 1'b1);
      send_word(WORD_W'(7), 1'b0);
      send_word(WORD_W'(9), 1'b1);
      // The smallest proper modulus with the largest weight.
      configure(WORD_W'(2), ALL_ONES);
      send_word(ALL_ONES, 1'b0);
      send_word(WORD_W'(1), 1'b0);
      send_word('0, 1'b1);
      // Weight zero drops everything after the first word of the run.
      configure(ALL_ONES, '0);
      send_word(WORD_W'(5), 1'b0);
      send_word(ALL_ONES, 1'b1);
      // Modulus just above 2^63, so that modular sums need the carry bit.
      configure({1'b1, {(WORD_W-2){1'b0}}, 1'b1}, ALL_ONES - 1);
      send_word(ALL_ONES, 1'b0);
      send_word({1'b0, {(WORD_W-1){1'b1}}}, 1'b1);
   endtask

   // A register written in the middle of a run applies from the next word on,
   // with the running state kept; a smaller modulus leaves the power above q.
   task automatic test_midrun_write();
      configure(ALL_ONES, 64'h0123_4567_89AB_CDEF);
      send_word({$urandom, $urandom}, 1'b0);
      send_word(ALL_ONES, 1'b0);
      send_word({$urandom, $urandom}, 1'b0);
      settle_idle();
      write_register(CSR_MODULUS, WORD_W'(1009));
      csr_bus.valid <= 1'b0;
      send_word(ALL_ONES, 1'b0);
      send_word({$urandom, $urandom}, 1'b1);
      send_word({$urandom, $urandom}, 1'b0);
      settle_idle();
      write_register(CSR_WEIGHT, ALL_ONES);
      csr_bus.valid <= 1'b0;
      send_word(ALL_ONES, 1'b1);
   endtask

   // The result side stops for a long stretch while single-word runs keep coming,
   // so the result register fills and the block has to stall its input.
   task automatic test_result_backpressure();
      configure(random_modulus(), {$urandom, $urandom});
      req_steady = 1'b1;
      hold_request = PRESSURE_HOLD;
      repeat (10) send_word(random_value(), 1'b1);
      req_steady = 1'b0;
   endtask

   // Random runs in phases of fresh settings. Each phase may also run without
   // idling on either side, and now and then a register is rewritten mid-run.
   task automatic test_random_runs();
      int unsigned sent;
      int unsigned run_len;
      int unsigned k;
      sent = 0;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         configure(random_modulus(), random_value());
         while (sent < (phase + 1) * (RANDOM_WORDS / PHASES)) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(1, 8);
            for (k = 1; k <= run_len; k++) begin
               send_word(random_value(), k == run_len);
               sent++;
               if (k != run_len && $urandom_range(0, 29) == 0) begin
                  settle_idle();
                  if ($urandom_range(0, 1) == 1) begin
                     write_register(CSR_MODULUS, random_modulus());
                  end else begin
                     write_register(CSR_WEIGHT, random_value());
                  end
                  csr_bus.valid <= 1'b0;
               end
            end
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // Result sink. After each accepted residue it draws how long to hold ready low;
   // a pending long hold overrides that draw. Outputs are read right after the
   // edge, so they hold the values that the edge itself sampled.
   initial begin : result_sink
      int unsigned wait_cycles;
      rsp_bus.ready <= 1'b0;
      wait_cycles = draw_gap(rsp_steady);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_residue(rsp_bus.residue);
            wait_cycles = draw_gap(rsp_steady);
         end
         if (hold_request > 0) begin
            wait_cycles = hold_request;
            hold_request = 0;
         end
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            wait_cycles--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // A hung handshake or a lost residue ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.last_value <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_MODULUS;
      csr_bus.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_modulus_extremes();
      test_midrun_write();
      test_result_backpressure();
      test_random_runs();

      settle_idle();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
